@@ rtl/core/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants of the RGB to HSV converter
// Holds the widths of the datapath and the record that travels down the
// chain of divider cells.
// ----------------------------------------------------------------------------
package rhc_pkg;

    // Width of one colour channel.
    localparam int CH_W   = 8;
    // Number of fraction bits of hue and saturation, one divider cell each.
    localparam int FRAC_W = 16;
    // Width of the hue divisor, six times the channel spread.
    localparam int HDIV_W = 11;

    // Record handed from cell to cell: partial remainders, divisors and the
    // quotient bits gathered so far for both divisions.
    typedef struct packed {
        logic [HDIV_W-1:0] rem_h;
        logic [HDIV_W-1:0] div_h;
        logic [FRAC_W-1:0] quo_h;
        logic [CH_W-1:0]   rem_s;
        logic [CH_W-1:0]   div_s;
        logic [FRAC_W-1:0] quo_s;
        logic              sat_full;
        logic [CH_W-1:0]   max_val;
    } t_cell_data;

endpackage

@@ rtl/core/rhc_front.sv @@
// ----------------------------------------------------------------------------
// rhc_front: first cell of the converter
// Finds maximum, minimum and spread of the pixel, picks the hue sector and
// sets up both divisions for the bit cells that follow.
// ----------------------------------------------------------------------------
module rhc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rhc_pkg::CH_W-1:0]      i_red,
    input  logic [rhc_pkg::CH_W-1:0]      i_green,
    input  logic [rhc_pkg::CH_W-1:0]      i_blue,
    output logic                          o_valid,
    input  logic                          i_ready,
    output rhc_pkg::t_cell_data           o_data
);

    logic                          r_valid;
    rhc_pkg::t_cell_data           r_data;
    rhc_pkg::t_cell_data           n_data;

    logic [rhc_pkg::CH_W-1:0]      max_val;
    logic [rhc_pkg::CH_W-1:0]      min_val;
    logic [rhc_pkg::CH_W-1:0]      delta;
    logic [rhc_pkg::HDIV_W-1:0]    six_delta;
    logic signed [11:0]            num_raw;
    logic signed [11:0]            num_wrap;

    // The cell takes a new transfer whenever it is empty or being drained.
    assign o_ready = !r_valid || i_ready;

    // Channel extremes and spread.
    always_comb begin
        max_val = i_red;
        if (i_green > max_val) max_val = i_green;
        if (i_blue > max_val)  max_val = i_blue;
        min_val = i_red;
        if (i_green < min_val) min_val = i_green;
        if (i_blue < min_val)  min_val = i_blue;
        delta     = max_val - min_val;
        six_delta = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
    end

    // Hue numerator; on ties blue wins over green, green over red.
    always_comb begin
        if (i_blue >= i_red && i_blue >= i_green) begin
            num_raw = $signed({2'b00, delta, 2'b00})
                    + $signed({4'b0000, i_red}) - $signed({4'b0000, i_green});
        end else if (i_green >= i_red && i_green >= i_blue) begin
            num_raw = $signed({3'b000, delta, 1'b0})
                    + $signed({4'b0000, i_blue}) - $signed({4'b0000, i_red});
        end else begin
            num_raw = $signed({4'b0000, i_green}) - $signed({4'b0000, i_blue});
        end
        if (num_raw < 0) begin
            num_wrap = num_raw + $signed({1'b0, six_delta});
        end else begin
            num_wrap = num_raw;
        end
    end

    // Division set-up. A grey pixel divides zero by one, giving a zero hue;
    // black gives a zero saturation the same way.
    always_comb begin
        n_data.rem_h    = num_wrap[rhc_pkg::HDIV_W-1:0];
        n_data.div_h    = (delta == '0) ? rhc_pkg::HDIV_W'(1) : six_delta;
        n_data.quo_h    = '0;
        n_data.rem_s    = delta;
        n_data.div_s    = (max_val == '0) ? rhc_pkg::CH_W'(1) : max_val;
        n_data.quo_s    = '0;
        n_data.sat_full = (max_val != '0) && (min_val == '0);
        n_data.max_val  = max_val;
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/core/rhc_div_cell.sv @@
// ----------------------------------------------------------------------------
// rhc_div_cell: one restoring division step for hue and saturation
// Doubles both partial remainders, subtracts the divisor where it fits and
// shifts the resulting quotient bit in.
// ----------------------------------------------------------------------------
module rhc_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rhc_pkg::t_cell_data  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rhc_pkg::t_cell_data  o_data
);

    logic                          r_valid;
    rhc_pkg::t_cell_data           r_data;
    rhc_pkg::t_cell_data           n_data;

    logic [rhc_pkg::HDIV_W:0]      rem_h2;
    logic [rhc_pkg::CH_W:0]        rem_s2;
    logic                          bit_h;
    logic                          bit_s;

    assign o_ready = !r_valid || i_ready;

    // One quotient bit of each division.
    always_comb begin
        rem_h2 = {i_data.rem_h, 1'b0};
        rem_s2 = {i_data.rem_s, 1'b0};
        bit_h  = rem_h2 >= {1'b0, i_data.div_h};
        bit_s  = rem_s2 >= {1'b0, i_data.div_s};

        n_data = i_data;
        if (bit_h) begin
            n_data.rem_h = rhc_pkg::HDIV_W'(rem_h2 - {1'b0, i_data.div_h});
        end else begin
            n_data.rem_h = rem_h2[rhc_pkg::HDIV_W-1:0];
        end
        if (bit_s) begin
            n_data.rem_s = rhc_pkg::CH_W'(rem_s2 - {1'b0, i_data.div_s});
        end else begin
            n_data.rem_s = rem_s2[rhc_pkg::CH_W-1:0];
        end
        n_data.quo_h = {i_data.quo_h[rhc_pkg::FRAC_W-2:0], bit_h};
        n_data.quo_s = {i_data.quo_s[rhc_pkg::FRAC_W-2:0], bit_s};
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/core/rgb_to_hsv_converter_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit: streaming RGB to HSV pixel converter
// Front cell followed by a row of sixteen division cells.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock unless all cells are full. The front
// cell finds maximum, minimum and hue sector, then each of sixteen cells
// produces one fraction bit of both hue and saturation. Every cell holds its
// own item and passes it on as soon as the next cell has room, so a stalled
// output only stops the input once all cells are full. Brightness is the
// largest channel, saturation is spread over maximum (held at 65535 when the
// smallest channel is zero and the largest is not) and hue is the fraction
// of a full turn, zero for grey pixels.
module rgb_to_hsv_converter_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [rhc_pkg::CH_W-1:0]  i_red,
    input  logic [rhc_pkg::CH_W-1:0]  i_green,
    input  logic [rhc_pkg::CH_W-1:0]  i_blue,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [rhc_pkg::FRAC_W-1:0] o_hue,
    output logic [rhc_pkg::FRAC_W-1:0] o_saturation,
    output logic [rhc_pkg::CH_W-1:0]  o_brightness
);

    localparam int NCELL = rhc_pkg::FRAC_W;

    logic                 stg_valid [NCELL+1];
    logic                 stg_ready [NCELL+1];
    rhc_pkg::t_cell_data  stg_data  [NCELL+1];

    // Front cell.
    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (stg_valid[0]),
        .i_ready (stg_ready[0]),
        .o_data  (stg_data[0])
    );

    // Row of division cells.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rhc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .o_ready (stg_ready[k]),
            .i_data  (stg_data[k]),
            .o_valid (stg_valid[k+1]),
            .i_ready (stg_ready[k+1]),
            .o_data  (stg_data[k+1])
        );
    end

    // Last cell register is the output register.
    assign stg_ready[NCELL] = i_ready;
    assign o_valid          = stg_valid[NCELL];
    assign o_hue            = stg_data[NCELL].quo_h;
    assign o_saturation     = stg_data[NCELL].sat_full ? '1 : stg_data[NCELL].quo_s;
    assign o_brightness     = stg_data[NCELL].max_val;

    // An empty output register means the whole row has room.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled although the output register is empty");

    // A draining output lets the input side move as well.
    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled although the output is being drained");

    // Black pixels give zero hue and zero saturation.
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_brightness == '0) |-> (o_hue == '0 && o_saturation == '0))
        else $error("black pixel with nonzero hue or saturation");

endmodule
